>>> rtl/core/upd_pkg.sv
// Shared types, constants and character-class helpers for the URL percent decoder.
`timescale 1ns / 1ps
`default_nettype none

package upd_pkg;

    localparam logic [7:0] CHAR_PERCENT = 8'h25;
    localparam logic [7:0] CHAR_PLUS    = 8'h2B;
    localparam logic [7:0] CHAR_SPACE   = 8'h20;
    localparam logic [7:0] CHAR_NUL     = 8'h00;
    localparam logic [7:0] CHAR_ZERO    = 8'h30;
    localparam logic [7:0] CHAR_TWO     = 8'h32;
    localparam logic [7:0] CHAR_SEVEN   = 8'h37;
    localparam logic [7:0] CHAR_NINE    = 8'h39;
    localparam logic [7:0] CHAR_LC_A    = 8'h61;
    localparam logic [7:0] CHAR_LC_F    = 8'h66;
    localparam logic [7:0] CHAR_UC_A    = 8'h41;
    localparam logic [7:0] CHAR_UC_F    = 8'h46;
    localparam logic [7:0] BAD_CODE     = 8'hFF;

    localparam logic [7:0] PUNCT0_LO = 8'h20;
    localparam logic [7:0] PUNCT0_HI = 8'h2F;
    localparam logic [7:0] PUNCT1_LO = 8'h3A;
    localparam logic [7:0] PUNCT1_HI = 8'h40;
    localparam logic [7:0] PUNCT2_LO = 8'h5B;
    localparam logic [7:0] PUNCT2_HI = 8'h60;
    localparam logic [7:0] PUNCT3_LO = 8'h7B;
    localparam logic [7:0] PUNCT3_HI = 8'h7E;

    localparam int unsigned QUEUE_DEPTH = 3;

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_HIGH = 2'd1,
        PH_LOW  = 2'd2
    } t_phase;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } t_result;

    // count: number of result beats (0, 1 or 2); first goes out before second
    typedef struct packed {
        logic [1:0] count;
        t_result    first;
        t_result    second;
    } t_decode;

    function automatic logic in_punct(input logic [7:0] c);
        in_punct = (c >= PUNCT0_LO && c <= PUNCT0_HI) ||
                   (c >= PUNCT1_LO && c <= PUNCT1_HI) ||
                   (c >= PUNCT2_LO && c <= PUNCT2_HI) ||
                   (c >= PUNCT3_LO && c <= PUNCT3_HI);
    endfunction

    // bit 4 set marks a byte that is not a hex digit
    function automatic logic [4:0] hex_value(input logic [7:0] c);
        logic [7:0] v;
        v = 8'h10;
        if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
            v = c - CHAR_ZERO;
        end else if (c >= CHAR_LC_A && c <= CHAR_LC_F) begin
            v = c - CHAR_LC_A + 8'd10;
        end else if (c >= CHAR_UC_A && c <= CHAR_UC_F) begin
            v = c - CHAR_UC_A + 8'd10;
        end
        hex_value = v[4:0];
    endfunction

endpackage

`default_nettype wire

>>> rtl/core/url_percent_decoder.sv
// Top level of the streaming URL percent decoder.
`timescale 1ns / 1ps
`default_nettype none

// Streaming URL form decoder, one encoded byte per input beat. Plain bytes
// pass through, '+' becomes a space, and '%' followed by two bytes becomes one
// decoded byte when the first digit is '2'..'7', the second a hex digit of
// either case and the code a punctuation character; any other escape yields
// 0xFF. The '%' and the first escape digit give no output beat. A NUL byte is
// forwarded as the string terminator; a NUL that cuts an escape short gives
// 0xFF (tlast low) then 0x00 (tlast high) and drops the escape. Every other
// input gives exactly one output beat with tlast high. Throughput is one
// input byte per clock: the decode is a single combinational step from the
// escape-state registers into a three-entry output queue. The input stalls
// whenever two or more beats wait in the queue, as after a two-beat NUL abort
// or while the downstream side holds back.
module url_percent_decoder (
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        s_axis_tvalid,
    output logic       s_axis_tready,
    input  wire  [7:0] s_axis_tdata,   // [7:0] in_byte
    output logic       m_axis_tvalid,
    input  wire        m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [7:0] out_byte
    output logic       m_axis_tlast    // run_last
);

    logic             accept;
    upd_pkg::t_decode dec;
    logic             space;

    // take a beat only when the queue can absorb a two-beat result
    assign s_axis_tready = space;
    assign accept        = s_axis_tvalid && space;

    upd_decode u_decode (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_byte   (s_axis_tdata),
        .o_dec    (dec)
    );

    upd_out_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (accept),
        .i_dec   (dec),
        .o_space (space),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_data  (m_axis_tdata),
        .o_last  (m_axis_tlast)
    );

endmodule

`default_nettype wire

>>> rtl/core/upd_decode.sv
// Escape-state tracking and per-byte decode into up to two result beats.
`timescale 1ns / 1ps
`default_nettype none

module upd_decode (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_accept,
    input  wire  [7:0]           i_byte,
    output upd_pkg::t_decode     o_dec
);

    upd_pkg::t_phase r_phase;
    upd_pkg::t_phase n_phase;
    logic [2:0]      r_high_digit;
    logic [2:0]      n_high_digit;
    logic            r_high_ok;
    logic            n_high_ok;

    logic [4:0] lo_val;
    logic [7:0] code;
    logic       in_escape;

    assign in_escape = (r_phase == upd_pkg::PH_HIGH) || (r_phase == upd_pkg::PH_LOW);
    assign lo_val    = upd_pkg::hex_value(i_byte);
    assign code      = {1'b0, r_high_digit, lo_val[3:0]};

    // next state
    always_comb begin
        n_phase      = upd_pkg::PH_IDLE;
        n_high_digit = 3'd0;
        n_high_ok    = 1'b0;
        case (r_phase)
            upd_pkg::PH_HIGH: begin
                if (i_byte != upd_pkg::CHAR_NUL) begin
                    n_phase      = upd_pkg::PH_LOW;
                    n_high_digit = i_byte[2:0];
                    n_high_ok    = (i_byte >= upd_pkg::CHAR_TWO) &&
                                   (i_byte <= upd_pkg::CHAR_SEVEN);
                end
            end
            upd_pkg::PH_LOW: begin
                n_phase = upd_pkg::PH_IDLE;
            end
            default: begin
                if (i_byte == upd_pkg::CHAR_PERCENT) begin
                    n_phase = upd_pkg::PH_HIGH;
                end
            end
        endcase
    end

    // result beats
    always_comb begin
        o_dec.count       = 2'd1;
        o_dec.first.data  = i_byte;
        o_dec.first.last  = 1'b1;
        o_dec.second.data = upd_pkg::CHAR_NUL;
        o_dec.second.last = 1'b1;
        if (in_escape && i_byte == upd_pkg::CHAR_NUL) begin
            o_dec.count       = 2'd2;
            o_dec.first.data  = upd_pkg::BAD_CODE;
            o_dec.first.last  = 1'b0;
        end else begin
            case (r_phase)
                upd_pkg::PH_HIGH: begin
                    o_dec.count = 2'd0;
                end
                upd_pkg::PH_LOW: begin
                    if (r_high_ok && !lo_val[4] && upd_pkg::in_punct(code)) begin
                        o_dec.first.data = code;
                    end else begin
                        o_dec.first.data = upd_pkg::BAD_CODE;
                    end
                end
                default: begin
                    if (i_byte == upd_pkg::CHAR_PERCENT) begin
                        o_dec.count = 2'd0;
                    end else if (i_byte == upd_pkg::CHAR_PLUS) begin
                        o_dec.first.data = upd_pkg::CHAR_SPACE;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= upd_pkg::PH_IDLE;
            r_high_digit <= 3'd0;
            r_high_ok    <= 1'b0;
        end else if (i_accept) begin
            r_phase      <= n_phase;
            r_high_digit <= n_high_digit;
            r_high_ok    <= n_high_ok;
        end
    end

`ifndef SYNTHESIS
    // a terminator always closes any open escape
    a_nul_closes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && i_byte == upd_pkg::CHAR_NUL) |=> (r_phase == upd_pkg::PH_IDLE))
        else $error("escape left open after NUL");
    // two beats come only from a NUL cutting an escape short
    a_two_beats: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_dec.count == 2'd2) |-> (in_escape && i_byte == upd_pkg::CHAR_NUL))
        else $error("double result outside escape abort");
`endif

endmodule

`default_nettype wire

>>> rtl/core/upd_out_queue.sv
// Three-entry result queue that takes up to two beats per cycle and drives the output stream.
`timescale 1ns / 1ps
`default_nettype none

module upd_out_queue (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_push,
    input  wire upd_pkg::t_decode i_dec,
    output logic                 o_space,
    output logic                 o_valid,
    input  wire                  i_ready,
    output logic [7:0]           o_data,
    output logic                 o_last
);

    upd_pkg::t_result r_mem [upd_pkg::QUEUE_DEPTH];
    logic [1:0] r_wr;
    logic [1:0] r_rd;
    logic [1:0] r_count;
    logic [1:0] n_count;
    logic [1:0] push_cnt;
    logic       pop;
    logic [1:0] wr_next;

    function automatic logic [1:0] ptr_inc(input logic [1:0] p);
        ptr_inc = (p == 2'(upd_pkg::QUEUE_DEPTH - 1)) ? 2'd0 : p + 2'd1;
    endfunction

    assign wr_next  = ptr_inc(r_wr);
    assign push_cnt = i_push ? i_dec.count : 2'd0;
    assign pop      = o_valid && i_ready;
    assign n_count  = r_count + push_cnt - {1'b0, pop};

    // room for a worst-case two-beat item
    assign o_space = (r_count <= 2'd1);
    assign o_valid = (r_count != 2'd0);
    assign o_data  = r_mem[r_rd].data;
    assign o_last  = r_mem[r_rd].last;

    always_ff @(posedge i_clk) begin
        if (push_cnt != 2'd0) begin
            r_mem[r_wr] <= i_dec.first;
        end
        if (push_cnt == 2'd2) begin
            r_mem[wr_next] <= i_dec.second;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= 2'd0;
            r_rd    <= 2'd0;
            r_count <= 2'd0;
        end else begin
            r_count <= n_count;
            if (pop) begin
                r_rd <= ptr_inc(r_rd);
            end
            if (push_cnt == 2'd1) begin
                r_wr <= wr_next;
            end else if (push_cnt == 2'd2) begin
                r_wr <= ptr_inc(wr_next);
            end
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push_cnt != 2'd0) |-> (r_count <= 2'd1))
        else $error("push into a queue without room");
    a_drain_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (pop && push_cnt == 2'd0) |=> (r_count == $past(r_count) - 2'd1))
        else $error("count did not drop on pop");
    a_fill_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!pop && push_cnt != 2'd0) |=> (r_count == $past(r_count) + $past(push_cnt)))
        else $error("count did not follow push");
`endif

endmodule

`default_nettype wire
